/* rtl/teq_pkg.sv */
package teq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 8;
    localparam int TICK_BITS   = 32;

    // Port widths fixed by the interface
    localparam int DELAY_W   = 16;
    localparam int EVTAG_W   = 8;
    localparam int STATUS_W  = 2;
    localparam int FTICK_W   = 32;
    localparam int PENDING_W = 5;

    localparam int ADDR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int PHYS_DEPTH = 1 << ADDR_W;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W     = ((TICK_BITS > DELAY_W) ? TICK_BITS : DELAY_W) + 1;

    localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};
    localparam logic [CNT_W-1:0]     CNT_FULL = CNT_W'(QUEUE_DEPTH);

    typedef enum logic [0:0] {
        CMD_SCHEDULE = 1'b0,
        CMD_FIRE     = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_SCHEDULED = 2'd0,
        ST_FIRED     = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        logic [TICK_BITS-1:0] deadline;
        logic [TAG_BITS-1:0]  tag;
    } teq_entry_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        teq_entry_t        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } teq_store_ctrl_t;

endpackage

/* rtl/timer_event_queue_unit.sv */
// Timer event queue. Up to QUEUE_DEPTH events (deadline, tag) are kept in
// deadline order in a single-port-write, single-port-read entry store used
// as a ring: the head pointer marks the earliest event. A schedule
// transaction (cmd 0) stores the tag with deadline = tick + delay
// (saturating) by walking from the tail toward the head, one entry per
// cycle, moving each later-deadline entry up by one slot; equal deadlines
// keep insertion order. A fire transaction (cmd 1) pops the head, moves the
// tick up to the deadline if it lies ahead, reports tag and fire tick, then
// advances the tick by one (saturating). Every input transaction yields
// exactly one result transaction with status, fired tag, fire tick and the
// number of pending events. The unit takes one transaction at a time:
// a full or an empty case goes straight to the response state, a fire
// reads the head and passes through the fire state, and a schedule walks
// one compare-and-move step per stored event with a later deadline (up to
// QUEUE_DEPTH - 1) before the new entry is written. Input ready returns in
// the cycle after the result is loaded, so no new transaction is accepted
// before the last has reached the result register; a stalled result
// register holds the unit in its response state until it drains. No
// clearing pass is needed after reset; the store holds no data until written.
module timer_event_queue_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_cmd,
    input  logic [teq_pkg::DELAY_W-1:0]  s_delay,
    input  logic [teq_pkg::EVTAG_W-1:0]  s_event_tag,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [teq_pkg::STATUS_W-1:0] m_status,
    output logic [teq_pkg::EVTAG_W-1:0]  m_fired_tag,
    output logic [teq_pkg::FTICK_W-1:0]  m_fire_tick,
    output logic [teq_pkg::PENDING_W-1:0] m_pending
);
    import teq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMP  = 5'b00010,
        S_INS  = 5'b00100,
        S_FIRE = 5'b01000,
        S_RESP = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic [ADDR_W-1:0]    head_reg, head_next;
    logic [TICK_BITS-1:0] tick_reg, tick_next;
    logic [TICK_BITS-1:0] due_reg, due_next;
    logic [TAG_BITS-1:0]  new_tag_reg, new_tag_next;
    status_t              status_reg, status_next;
    logic [TAG_BITS-1:0]  res_tag_reg, res_tag_next;
    logic [TICK_BITS-1:0] res_tick_reg, res_tick_next;

    logic                 m_valid_reg, m_valid_next;
    status_t              m_status_reg, m_status_next;
    logic [EVTAG_W-1:0]   m_tag_reg, m_tag_next;
    logic [FTICK_W-1:0]   m_tick_reg, m_tick_next;
    logic [PENDING_W-1:0] m_pending_reg, m_pending_next;

    teq_store_ctrl_t store_ctrl;
    teq_entry_t      rd_entry;

    logic [SUM_W-1:0]     due_sum;
    logic [TICK_BITS-1:0] due_sat;
    logic [CNT_W-1:0]     pos_dec;
    logic [CNT_W-1:0]     cnt_dec;
    logic [TICK_BITS-1:0] when_tick;
    logic                 s_fire;
    logic                 out_free;

    teq_entry_store u_store (
        .aclk    (aclk),
        .ctrl    (store_ctrl),
        .rd_data (rd_entry)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Saturating deadline: tick + delay, clamp at the tick maximum
    assign due_sum = SUM_W'(tick_reg) + SUM_W'(s_delay);
    assign due_sat = (due_sum[SUM_W-1:TICK_BITS] != '0) ? TICK_MAX
                                                       : due_sum[TICK_BITS-1:0];
    assign pos_dec = pos_reg - CNT_W'(1);
    assign cnt_dec = count_reg - CNT_W'(1);
    assign when_tick = (rd_entry.deadline > tick_reg) ? rd_entry.deadline : tick_reg;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        head_next     = head_reg;
        tick_next     = tick_reg;
        due_next      = due_reg;
        new_tag_next  = new_tag_reg;
        status_next   = status_reg;
        res_tag_next  = res_tag_reg;
        res_tick_next = res_tick_reg;

        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_tag_next     = m_tag_reg;
        m_tick_next    = m_tick_reg;
        m_pending_next = m_pending_reg;

        store_ctrl.wr_en   = 1'b0;
        store_ctrl.wr_addr = head_reg + pos_reg[ADDR_W-1:0];
        store_ctrl.wr_data = '{deadline: due_reg, tag: new_tag_reg};
        store_ctrl.rd_en   = 1'b0;
        store_ctrl.rd_addr = head_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    res_tag_next  = '0;
                    res_tick_next = tick_reg;
                    due_next      = due_sat;
                    new_tag_next  = TAG_BITS'(s_event_tag);
                    pos_next      = count_reg;
                    if (s_cmd == CMD_SCHEDULE) begin
                        if (count_reg >= CNT_FULL) begin
                            status_next = ST_FULL;
                            state_next  = S_RESP;
                        end else if (count_reg == '0) begin
                            state_next = S_INS;
                        end else begin
                            // Fetch the tail entry for the first compare
                            store_ctrl.rd_en   = 1'b1;
                            store_ctrl.rd_addr = head_reg + cnt_dec[ADDR_W-1:0];
                            state_next = S_CMP;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            status_next = ST_EMPTY;
                            state_next  = S_RESP;
                        end else begin
                            store_ctrl.rd_en   = 1'b1;
                            store_ctrl.rd_addr = head_reg;
                            state_next = S_FIRE;
                        end
                    end
                end
            end
            S_CMP: begin
                store_ctrl.wr_en = 1'b1;
                if (rd_entry.deadline > due_reg) begin
                    // Move the later entry up one slot, keep walking
                    store_ctrl.wr_data = rd_entry;
                    pos_next = pos_dec;
                    if (pos_dec == '0) begin
                        state_next = S_INS;
                    end else begin
                        store_ctrl.rd_en   = 1'b1;
                        store_ctrl.rd_addr = head_reg + pos_dec[ADDR_W-1:0] -
                                             ADDR_W'(1);
                    end
                end else begin
                    count_next  = count_reg + CNT_W'(1);
                    status_next = ST_SCHEDULED;
                    state_next  = S_RESP;
                end
            end
            S_INS: begin
                store_ctrl.wr_en = 1'b1;
                count_next  = count_reg + CNT_W'(1);
                status_next = ST_SCHEDULED;
                state_next  = S_RESP;
            end
            S_FIRE: begin
                head_next     = head_reg + ADDR_W'(1);
                count_next    = cnt_dec;
                res_tag_next  = rd_entry.tag;
                res_tick_next = when_tick;
                tick_next     = (when_tick == TICK_MAX) ? TICK_MAX
                                                        : when_tick + TICK_BITS'(1);
                status_next   = ST_FIRED;
                state_next    = S_RESP;
            end
            S_RESP: begin
                // Hold the result until the output register is free
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = status_reg;
                    m_tag_next     = EVTAG_W'(res_tag_reg);
                    m_tick_next    = FTICK_W'(res_tick_reg);
                    m_pending_next = PENDING_W'(count_reg);
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            head_reg    <= '0;
            tick_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            tick_reg    <= tick_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg       <= pos_next;
        due_reg       <= due_next;
        new_tag_reg   <= new_tag_next;
        status_reg    <= status_next;
        res_tag_reg   <= res_tag_next;
        res_tick_reg  <= res_tick_next;
        m_status_reg  <= m_status_next;
        m_tag_reg     <= m_tag_next;
        m_tick_reg    <= m_tick_next;
        m_pending_reg <= m_pending_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_fired_tag = m_tag_reg;
    assign m_fire_tick = m_tick_reg;
    assign m_pending   = m_pending_reg;

endmodule

/* rtl/teq_entry_store.sv */
module teq_entry_store (
    input  logic                     aclk,
    input  teq_pkg::teq_store_ctrl_t ctrl,
    output teq_pkg::teq_entry_t      rd_data
);
    import teq_pkg::*;

    teq_entry_t mem [PHYS_DEPTH];
    teq_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[ctrl.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* verif/timer_event_queue_unit_tb.sv */
`timescale 1ns / 1ps

module timer_event_queue_unit_tb;
    import teq_pkg::*;

    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_ITEMS  = 530;

    typedef struct {
        status_t               status;
        logic [EVTAG_W-1:0]    tag;
        logic [FTICK_W-1:0]    tick;
        logic [PENDING_W-1:0]  pending;
    } timer_result_t;

    logic                  aclk;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic                  s_cmd       = CMD_SCHEDULE;
    logic [DELAY_W-1:0]    s_delay     = '0;
    logic [EVTAG_W-1:0]    s_event_tag = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [EVTAG_W-1:0]    m_fired_tag;
    logic [FTICK_W-1:0]    m_fire_tick;
    logic [PENDING_W-1:0]  m_pending;

    // Shadow copy of the queue contents, kept in firing order, and the tick.
    teq_entry_t            pending_events[$];
    logic [TICK_BITS-1:0]  model_tick = '0;

    // Results predicted at input acceptance, oldest first.
    timer_result_t         expected_results[$];

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int ready_hold_cycles = 0;
    int mismatch_count    = 0;
    int cycle_count       = 0;

    timer_event_queue_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_delay     (s_delay),
        .s_event_tag (s_event_tag),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_fired_tag (m_fired_tag),
        .m_fire_tick (m_fire_tick),
        .m_pending   (m_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Apply one command to the shadow queue and return the result it produces.
    function automatic timer_result_t apply_timer_command(input cmd_t cmd,
                                                          input logic [DELAY_W-1:0] delay,
                                                          input logic [EVTAG_W-1:0] tag);
        timer_result_t        res;
        teq_entry_t           entry;
        logic [TICK_BITS:0]   sum;
        logic [TICK_BITS-1:0] fired_at;
        int                   pos;

        res.tag  = '0;
        res.tick = FTICK_W'(model_tick);
        if (cmd == CMD_SCHEDULE) begin
            if (pending_events.size() >= QUEUE_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                // Saturate the deadline at the top of the tick range.
                sum = {1'b0, model_tick} + (TICK_BITS + 1)'(delay);
                entry.deadline = sum[TICK_BITS] ? TICK_MAX : sum[TICK_BITS-1:0];
                entry.tag      = TAG_BITS'(tag);
                // Place after every entry due at or before the new one: FIFO on ties.
                pos = pending_events.size();
                while (pos > 0 && pending_events[pos-1].deadline > entry.deadline)
                    pos--;
                pending_events.insert(pos, entry);
                res.status = ST_SCHEDULED;
            end
        end else if (pending_events.size() == 0) begin
            res.status = ST_EMPTY;
        end else begin
            entry = pending_events.pop_front();
            if (entry.deadline > model_tick)
                model_tick = entry.deadline;
            fired_at = model_tick;
            if (model_tick != TICK_MAX)
                model_tick = model_tick + 1'b1;
            res.status = ST_FIRED;
            res.tag    = EVTAG_W'(entry.tag);
            res.tick   = FTICK_W'(fired_at);
        end
        res.pending = PENDING_W'(pending_events.size());
        return res;
    endfunction

    // Offer one transaction, hold it until accepted, then record its expected result.
    task automatic send_command(input cmd_t cmd, input logic [DELAY_W-1:0] delay,
                                input logic [EVTAG_W-1:0] tag);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_delay     <= delay;
        s_event_tag <= tag;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(apply_timer_command(cmd, delay, tag));
    endtask

    // Drop valid and hold off until every outstanding result has come back.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    function automatic logic [DELAY_W-1:0] pick_delay();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return DELAY_W'($urandom_range(15));
            default: return DELAY_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    task automatic test_fire_on_empty();
        send_command(CMD_FIRE, '0, '0);
    endtask

    // Shortest and longest delay with the all-zero and all-one tags.
    task automatic test_delay_extremes();
        send_command(CMD_SCHEDULE, '0, '0);
        send_command(CMD_SCHEDULE, '1, '1);
        send_command(CMD_FIRE, '0, '0);
        send_command(CMD_FIRE, '1, '1);
    endtask

    // Two events share a deadline, a third lands ahead of both.
    task automatic test_equal_deadlines();
        send_command(CMD_SCHEDULE, 16'd5, 8'hA1);
        send_command(CMD_SCHEDULE, 16'd5, 8'hA2);
        send_command(CMD_SCHEDULE, 16'd2, 8'hA3);
        repeat (3) send_command(CMD_FIRE, '0, '0);
    endtask

    // Fill with falling deadlines so every insert walks the whole queue, overflow it,
    // then fire once from the full queue. The rest stays queued for the random traffic.
    task automatic test_queue_full();
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_command(CMD_SCHEDULE, DELAY_W'(1000 - 50 * i), (i % 2) ? 8'h55 : 8'hAA);
        send_command(CMD_SCHEDULE, 16'd7, 8'hFF);
        send_command(CMD_FIRE, '0, '0);
    endtask

    // Stall the result side for a long stretch while inputs keep coming.
    task automatic test_receiver_hold_off();
        int saved_idle;

        saved_idle        = sender_idle_pct;
        sender_idle_pct   = 0;
        ready_hold_cycles = 300;
        for (int i = 0; i < 10; i++)
            send_command(cmd_t'($urandom_range(1)), pick_delay(), EVTAG_W'($urandom));
        sender_idle_pct = saved_idle;
    endtask

    task automatic test_sender_pause();
        for (int i = 0; i < 4; i++)
            send_command(cmd_t'($urandom_range(1)), pick_delay(), EVTAG_W'($urandom));
        wait_for_results();
    endtask

    // Random traffic; the fire share changes in bursts so the queue swings
    // between empty and full.
    task automatic test_random_traffic(input int count);
        int   fire_pct;
        cmd_t cmd;

        fire_pct = 50;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0)
                fire_pct = 25 * $urandom_range(1, 3);
            cmd = ($urandom_range(99) < fire_pct) ? CMD_FIRE : CMD_SCHEDULE;
            send_command(cmd, pick_delay(), EVTAG_W'($urandom));
        end
    endtask

    // Drain the backlog, then schedule three events out of deadline order and
    // fire once more than there are events, ending on the empty queue.
    task automatic test_drain_and_reorder();
        int backlog;

        backlog = pending_events.size();
        repeat (backlog) send_command(CMD_FIRE, '0, '0);
        send_command(CMD_SCHEDULE, '1, 8'h11);
        send_command(CMD_SCHEDULE, '0, 8'h22);
        send_command(CMD_SCHEDULE, 16'd9, 8'h33);
        repeat (4) send_command(CMD_FIRE, '0, '0);
    endtask

    // Result side: random stalls, or a counted hold-off when one is requested.
    always @(posedge aclk) begin
        if (ready_hold_cycles > 0) begin
            m_ready <= 1'b0;
            ready_hold_cycles = ready_hold_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Compare each accepted result against the oldest prediction.
    always @(posedge aclk) begin
        timer_result_t want;

        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d tag %0d tick %0d",
                         $time, m_status, m_fired_tag, m_fire_tick);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, m_status);
                    mismatch_count++;
                end
                if (m_fired_tag !== want.tag) begin
                    $display("%0t: fired_tag mismatch, expected %0d, actual %0d",
                             $time, want.tag, m_fired_tag);
                    mismatch_count++;
                end
                if (m_fire_tick !== want.tick) begin
                    $display("%0t: fire_tick mismatch, expected %0d, actual %0d",
                             $time, want.tick, m_fire_tick);
                    mismatch_count++;
                end
                if (m_pending !== want.pending) begin
                    $display("%0t: pending mismatch, expected %0d, actual %0d",
                             $time, want.pending, m_pending);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: abort a run that hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        sender_idle_pct   = 30;
        receiver_idle_pct = 46;
        test_fire_on_empty();
        test_delay_extremes();
        test_equal_deadlines();
        test_queue_full();
        test_receiver_hold_off();
        test_sender_pause();

        test_random_traffic(RANDOM_ITEMS);
        sender_idle_pct   = 46;
        receiver_idle_pct = 30;
        test_random_traffic(RANDOM_ITEMS);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random_traffic(RANDOM_ITEMS);

        test_drain_and_reorder();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
